>>> src/pbacc_pkg.sv
package pbacc_pkg;

  // default number of entries per image
  localparam int ENTRIES_DEF = 4;

  // packed length register layout
  localparam int LEN_W = 8;
  localparam int PACKED = 4;
  localparam int PACKED_IDX_W = 2;
  localparam int LENGTHS_W = LEN_W * PACKED;

  // entry count register and walk counter (counts up to PACKED)
  localparam int COUNT_W = 3;

  // bit number and stored value widths
  localparam int BIT_W = 8;
  localparam int VALUE_W = 64;
  localparam int VALUE_IDX_W = 6;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_INDEX_W-1:0] REG_INPUT_LENGTHS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_LENGTHS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_INPUT_COUNT = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_COUNT = 2'd3;

  // request commands
  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_LOAD  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // status codes
  localparam logic [1:0] ST_GOOD = 2'd0;
  localparam logic [1:0] ST_OBJECT = 2'd1;
  localparam logic [1:0] ST_LENGTH = 2'd2;

  // result of one entry walk
  typedef struct packed {
    logic               done;
    logic               found;
    logic [COUNT_W-1:0] entry;
    logic [BIT_W-1:0]   pos;
  } locate_t;

endpackage

>>> src/pbacc_locate.sv
module pbacc_locate #(
  parameter int ENTRIES = pbacc_pkg::ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [pbacc_pkg::LENGTHS_W-1:0] lengths,
  input  logic [pbacc_pkg::COUNT_W-1:0]   count,
  input  logic [pbacc_pkg::BIT_W-1:0]     bit_number,
  output pbacc_pkg::locate_t              res
);
  import pbacc_pkg::*;

  localparam int LIMIT = (ENTRIES < PACKED) ? ENTRIES : PACKED;

  logic               busy;
  logic [COUNT_W-1:0] idx;
  logic [BIT_W-1:0]   rest;
  logic [COUNT_W-1:0] usable;
  logic [LEN_W-1:0]   len;

  // entries in use, saturated at what storage and the register hold
  assign usable = (count > COUNT_W'(LIMIT)) ? COUNT_W'(LIMIT) : count;

  // length of the entry under examination
  assign len = lengths[idx[PACKED_IDX_W-1:0] * LEN_W +: LEN_W];

  // one entry per cycle through a single compare and subtract
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      res.done <= 1'b0;
    end else begin
      res.done <= busy && !start && ((idx >= usable) || (rest < len));
      if (start) begin
        busy <= 1'b1;
        idx  <= '0;
        rest <= bit_number;
      end else if (busy) begin
        if (idx >= usable) begin
          busy      <= 1'b0;
          res.found <= 1'b0;
        end else if (rest < len) begin
          busy      <= 1'b0;
          res.found <= 1'b1;
          res.entry <= idx;
          res.pos   <= rest;
        end else begin
          rest <= rest - len;
          idx  <= idx + COUNT_W'(1);
        end
      end
    end
  end

endmodule

>>> src/process_image_bit_access_core.sv
// Bit-addressed access to an input and an output process image of ENTRIES
// 64-bit entries each, with per-entry bit lengths set through the write port.
// A read or write request locates its bit by walking the entries one per
// cycle through a single compare-and-subtract unit; loads, unused commands
// and object number errors skip the walk. One request is in work at a time;
// a new one is taken as soon as the previous one has reached the output
// register, even while that result still waits to be taken.
module process_image_bit_access_core #(
  parameter int ENTRIES = pbacc_pkg::ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_write,
  input  logic [pbacc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pbacc_pkg::CFG_DATA_W-1:0]  cfg_data,
  // request channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        cmd,
  input  logic                              image_select,
  input  logic [1:0]                        object_number,
  input  logic [pbacc_pkg::BIT_W-1:0]       bit_number,
  input  logic                              bit_value,
  input  logic [1:0]                        entry_select,
  input  logic [pbacc_pkg::VALUE_W-1:0]     entry_value,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              read_bit,
  output logic [1:0]                        status
);
  import pbacc_pkg::*;

  localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FINISH
  } state_t;

  state_t state;

  // configuration registers
  logic [LENGTHS_W-1:0] input_lengths;
  logic [LENGTHS_W-1:0] output_lengths;
  logic [COUNT_W-1:0]   input_entry_count;
  logic [COUNT_W-1:0]   output_entry_count;

  // process images
  logic [VALUE_W-1:0] input_values [ENTRIES];
  logic [VALUE_W-1:0] output_values [ENTRIES];

  // latched request
  cmd_t               cmd_q;
  logic               to_output;
  logic               bit_value_q;
  logic [1:0]         entry_select_q;
  logic [VALUE_W-1:0] entry_value_q;
  logic               found_q;
  logic [EW-1:0]      entry_q;
  logic [BIT_W-1:0]   pos_q;
  logic [1:0]         status_q;

  logic     in_fire;
  logic     bit_cmd;
  logic     walk_start;
  logic     out_free;
  logic     pos_in_range;
  logic     load_ok;
  logic     read_value;
  locate_t  loc;

  assign in_ready   = (state == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign bit_cmd    = (cmd == CMD_READ) || (cmd == CMD_WRITE);
  assign walk_start = in_fire && bit_cmd && (object_number == 2'd0);
  assign out_free   = !out_valid || out_ready;

  // bit positions of 64 and above inside an entry read zero and are not written
  assign pos_in_range = (pos_q[BIT_W-1:VALUE_IDX_W] == '0);
  assign load_ok      = (32'(entry_select_q) < ENTRIES);

  // addressed bit of the selected image
  always_comb begin
    if (to_output) begin
      read_value = output_values[entry_q][pos_q[VALUE_IDX_W-1:0]];
    end else begin
      read_value = input_values[entry_q][pos_q[VALUE_IDX_W-1:0]];
    end
  end

  // entry walk
  pbacc_locate #(
    .ENTRIES(ENTRIES)
  ) u_locate (
    .clk        (clk),
    .rst        (rst),
    .start      (walk_start),
    .lengths    (to_output ? output_lengths : input_lengths),
    .count      (to_output ? output_entry_count : input_entry_count),
    .bit_number (bit_number),
    .res        (loc)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      input_lengths      <= LENGTHS_W'(8);
      output_lengths     <= LENGTHS_W'(8);
      input_entry_count  <= COUNT_W'(1);
      output_entry_count <= COUNT_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_INPUT_LENGTHS:  input_lengths      <= cfg_data;
        REG_OUTPUT_LENGTHS: output_lengths     <= cfg_data;
        REG_INPUT_COUNT:    input_entry_count  <= cfg_data[COUNT_W-1:0];
        REG_OUTPUT_COUNT:   output_entry_count <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer, images and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        input_values[i]  <= '0;
        output_values[i] <= '0;
      end
    end else begin
      if (out_valid && out_ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            cmd_q          <= cmd_t'(cmd);
            to_output      <= (cmd == CMD_WRITE) || image_select;
            bit_value_q    <= bit_value;
            entry_select_q <= entry_select;
            entry_value_q  <= entry_value;
            found_q        <= 1'b0;
            if (walk_start) begin
              state <= S_WALK;
            end else begin
              status_q <= bit_cmd ? ST_OBJECT : ST_GOOD;
              state    <= S_FINISH;
            end
          end
        end
        S_WALK: begin
          if (loc.done) begin
            found_q  <= loc.found;
            entry_q  <= EW'(loc.entry);
            pos_q    <= loc.pos;
            status_q <= loc.found ? ST_GOOD : ST_LENGTH;
            state    <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            status    <= status_q;
            read_bit  <= (cmd_q == CMD_READ) && found_q && pos_in_range && read_value;
            if (cmd_q == CMD_WRITE && found_q && pos_in_range) begin
              output_values[entry_q][pos_q[VALUE_IDX_W-1:0]] <= bit_value_q;
            end
            if (cmd_q == CMD_LOAD && load_ok) begin
              input_values[EW'(entry_select_q)] <= entry_value_q;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> tb/process_image_bit_access_checker.sv
module process_image_bit_access_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [pbacc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pbacc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [1:0]                        cmd,
  input  logic                              image_select,
  input  logic [1:0]                        object_number,
  input  logic [pbacc_pkg::BIT_W-1:0]       bit_number,
  input  logic                              bit_value,
  input  logic [1:0]                        entry_select,
  input  logic [pbacc_pkg::VALUE_W-1:0]     entry_value,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic                              read_bit,
  input  logic [1:0]                        status,
  output int                                mismatch_count,
  output int                                answers_pending
);

  timeunit 1ns;
  timeprecision 1ps;

  import pbacc_pkg::*;

  typedef struct packed {
    logic       read_bit;
    logic [1:0] status;
  } answer_t;

  // shadow of the configuration and of both images
  logic [LENGTHS_W-1:0] in_len_reg;
  logic [LENGTHS_W-1:0] out_len_reg;
  logic [COUNT_W-1:0]   in_cnt_reg;
  logic [COUNT_W-1:0]   out_cnt_reg;
  logic [VALUE_W-1:0]   in_image  [ENTRIES_DEF];
  logic [VALUE_W-1:0]   out_image [ENTRIES_DEF];

  answer_t answer_q [$];
  answer_t want;

  // serve one request against the shadow images, return its answer
  function automatic answer_t serve_request(cmd_t c, logic img, logic [1:0] obj,
                                            logic [BIT_W-1:0] bitn, logic val,
                                            logic [1:0] sel, logic [VALUE_W-1:0] word);
    answer_t              ans;
    logic                 to_out;
    logic [LENGTHS_W-1:0] lens;
    int                   used;
    int                   rest;
    int                   entry;
    int                   pos;
    bit                   found;
    ans   = '0;
    found = 1'b0;
    entry = 0;
    pos   = 0;
    if (c == CMD_READ || c == CMD_WRITE) begin
      to_out = (c == CMD_WRITE) || img;
      lens   = to_out ? out_len_reg : in_len_reg;
      used   = to_out ? int'(out_cnt_reg) : int'(in_cnt_reg);
      // count saturates at the entries present and the lengths packed
      if (used > ENTRIES_DEF) used = ENTRIES_DEF;
      if (used > PACKED) used = PACKED;
      // walk the entries, subtracting lengths
      rest = int'(bitn);
      for (int i = 0; i < used; i++) begin
        if (!found) begin
          if (rest < int'(lens[i*LEN_W +: LEN_W])) begin
            found = 1'b1;
            entry = i;
            pos   = rest;
          end else begin
            rest = rest - int'(lens[i*LEN_W +: LEN_W]);
          end
        end
      end
      if (obj != 2'd0) begin
        ans.status = ST_OBJECT;
      end else if (!found) begin
        ans.status = ST_LENGTH;
      end else if (c == CMD_READ) begin
        // positions past the 64 stored bits read as zero
        if (pos < VALUE_W) ans.read_bit = to_out ? out_image[entry][pos] : in_image[entry][pos];
      end else if (pos < VALUE_W) begin
        out_image[entry][pos] = val;
      end
    end else if (c == CMD_LOAD) begin
      in_image[sel] = word;
    end
    return ans;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      mismatch_count = 0;
      in_len_reg  = 32'd8;
      out_len_reg = 32'd8;
      in_cnt_reg  = 3'd1;
      out_cnt_reg = 3'd1;
      for (int i = 0; i < ENTRIES_DEF; i++) begin
        in_image[i]  = '0;
        out_image[i] = '0;
      end
      answer_q.delete();
    end else begin
      // register writes
      if (cfg_write) begin
        case (cfg_index)
          REG_INPUT_LENGTHS:  in_len_reg  = cfg_data;
          REG_OUTPUT_LENGTHS: out_len_reg = cfg_data;
          REG_INPUT_COUNT:    in_cnt_reg  = cfg_data[COUNT_W-1:0];
          REG_OUTPUT_COUNT:   out_cnt_reg = cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      // compare a taken result with the oldest answer
      if (out_valid && out_ready) begin
        if (answer_q.size() == 0) begin
          $error("result with no request pending: read_bit %0b status %0d", read_bit, status);
          mismatch_count++;
        end else begin
          want = answer_q.pop_front();
          if (read_bit !== want.read_bit) begin
            $error("read_bit mismatch: expected %0b, actual %0b", want.read_bit, read_bit);
            mismatch_count++;
          end
          if (status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, status);
            mismatch_count++;
          end
        end
      end
      // accepted request
      if (in_valid && in_ready) begin
        answer_q.push_back(serve_request(cmd_t'(cmd), image_select, object_number, bit_number,
                                         bit_value, entry_select, entry_value));
      end
    end
    answers_pending = answer_q.size();
  end

endmodule

>>> tb/tb_process_image_bit_access_core.sv
module tb_process_image_bit_access_core;

  timeunit 1ns;
  timeprecision 1ps;

  import pbacc_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 180;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  cmd_t                   cmd;
  logic                   image_select;
  logic [1:0]             object_number;
  logic [BIT_W-1:0]       bit_number;
  logic                   bit_value;
  logic [1:0]             entry_select;
  logic [VALUE_W-1:0]     entry_value;
  logic                   out_valid;
  logic                   out_ready;
  logic                   read_bit;
  logic [1:0]             status;
  int                     mismatch_count;
  int                     answers_pending;

  // idle rates in percent and the configuration now in force
  int                     send_idle_pct = 0;
  int                     recv_stall_pct = 0;
  logic [LENGTHS_W-1:0]   in_len_now = 32'd8;
  logic [LENGTHS_W-1:0]   out_len_now = 32'd8;
  logic [COUNT_W-1:0]     in_cnt_now = 3'd1;
  logic [COUNT_W-1:0]     out_cnt_now = 3'd1;
  int                     quiet_cycles = 0;

  process_image_bit_access_core i_dut (.*);

  process_image_bit_access_checker i_checker (.*);

  always #5 clk = ~clk;

  // result side back-pressure
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles without any accepted request or result
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic send_request(cmd_t c, logic img, logic [1:0] obj, logic [BIT_W-1:0] bitn,
                              logic val, logic [1:0] sel, logic [VALUE_W-1:0] word);
    @(negedge clk);
    // optional gap before the request
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      do begin
        @(negedge clk);
      end while ($urandom_range(0, 99) < send_idle_pct);
    end
    cmd           = c;
    image_select  = img;
    object_number = obj;
    bit_number    = bitn;
    bit_value     = val;
    entry_select  = sel;
    entry_value   = word;
    in_valid      = 1'b1;
    do begin
      @(posedge clk);
    end while (!in_ready);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (answers_pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic apply_config(logic [LENGTHS_W-1:0] in_len, logic [LENGTHS_W-1:0] out_len,
                              logic [COUNT_W-1:0] in_cnt, logic [COUNT_W-1:0] out_cnt);
    write_reg(REG_INPUT_LENGTHS, in_len);
    write_reg(REG_OUTPUT_LENGTHS, out_len);
    write_reg(REG_INPUT_COUNT, CFG_DATA_W'(in_cnt));
    write_reg(REG_OUTPUT_COUNT, CFG_DATA_W'(out_cnt));
    in_len_now  = in_len;
    out_len_now = out_len;
    in_cnt_now  = in_cnt;
    out_cnt_now = out_cnt;
  endtask

  // total bit length of the entries in use
  function automatic int image_span(logic [LENGTHS_W-1:0] lens, logic [COUNT_W-1:0] cnt);
    int used;
    int total;
    used  = (int'(cnt) > PACKED) ? PACKED : int'(cnt);
    total = 0;
    for (int k = 0; k < used; k++) total += int'(lens[k*LEN_W +: LEN_W]);
    return total;
  endfunction

  // random request, mostly aimed inside the addressed image
  task automatic random_request();
    int                 pick;
    int                 span;
    cmd_t               c;
    logic               img;
    logic [1:0]         obj;
    logic [BIT_W-1:0]   bitn;
    pick = $urandom_range(0, 99);
    if (pick < 40) c = CMD_READ;
    else if (pick < 70) c = CMD_WRITE;
    else if (pick < 95) c = CMD_LOAD;
    else c = CMD_NONE;
    img = 1'($urandom_range(0, 1));
    obj = ($urandom_range(0, 99) < 8) ? 2'($urandom_range(1, 3)) : 2'd0;
    if (c == CMD_WRITE || img) span = image_span(out_len_now, out_cnt_now);
    else span = image_span(in_len_now, in_cnt_now);
    if (span > 256) span = 256;
    if (span > 0 && $urandom_range(0, 99) < 85) bitn = BIT_W'($urandom_range(0, span - 1));
    else bitn = BIT_W'($urandom_range(0, 255));
    send_request(c, img, obj, bitn, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                 {$urandom, $urandom});
  endtask

  initial begin
    logic [LENGTHS_W-1:0] in_len;
    logic [LENGTHS_W-1:0] out_len;
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    cmd           = CMD_READ;
    image_select  = 1'b0;
    object_number = '0;
    bit_number    = '0;
    bit_value     = 1'b0;
    entry_select  = '0;
    entry_value   = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset configuration: one entry of 8 bits in each image
    send_request(CMD_READ, 1'b0, 2'd0, 8'd0, 1'b0, 2'd0, '0);
    send_request(CMD_WRITE, 1'b0, 2'd0, 8'd0, 1'b1, 2'd0, '0);
    send_request(CMD_READ, 1'b1, 2'd0, 8'd0, 1'b0, 2'd0, '0);
    send_request(CMD_READ, 1'b0, 2'd0, 8'd8, 1'b0, 2'd0, '0);
    send_request(CMD_READ, 1'b0, 2'd0, 8'd255, 1'b0, 2'd0, '0);
    send_request(CMD_READ, 1'b1, 2'd3, 8'd0, 1'b0, 2'd0, '0);
    send_request(CMD_WRITE, 1'b0, 2'd1, 8'd1, 1'b1, 2'd0, '0);
    send_request(CMD_WRITE, 1'b0, 2'd2, 8'd0, 1'b0, 2'd0, '0);
    send_request(CMD_NONE, 1'b1, 2'd3, 8'd255, 1'b1, 2'd3, '1);
    send_request(CMD_LOAD, 1'b0, 2'd0, 8'd0, 1'b0, 2'd0, '1);
    send_request(CMD_READ, 1'b0, 2'd0, 8'd7, 1'b0, 2'd0, '0);
    send_request(CMD_LOAD, 1'b0, 2'd0, 8'd0, 1'b0, 2'd3, '0);
    send_request(CMD_LOAD, 1'b0, 2'd0, 8'd0, 1'b0, 2'd2, 64'hA5A5_0F0F_C3C3_5A5A);

    // widest lengths, count past the entries, lengths above 64
    wait_idle();
    apply_config(32'hFFFF_FFFF, 32'h4040_4040, 3'd7, 3'd4);
    send_request(CMD_READ, 1'b0, 2'd0, 8'd200, 1'b0, 2'd0, '0);
    send_request(CMD_LOAD, 1'b0, 2'd0, 8'd0, 1'b0, 2'd1, 64'h1);
    send_request(CMD_READ, 1'b0, 2'd0, 8'd255, 1'b0, 2'd0, '0);
    send_request(CMD_WRITE, 1'b0, 2'd0, 8'd255, 1'b1, 2'd0, '0);
    send_request(CMD_READ, 1'b1, 2'd0, 8'd255, 1'b0, 2'd0, '0);
    send_request(CMD_WRITE, 1'b1, 2'd0, 8'd0, 1'b0, 2'd0, '0);
    send_request(CMD_READ, 1'b1, 2'd0, 8'd0, 1'b0, 2'd0, '0);

    // no entry in use
    wait_idle();
    apply_config(32'd0, 32'd0, 3'd0, 3'd0);
    send_request(CMD_READ, 1'b0, 2'd0, 8'd0, 1'b0, 2'd0, '0);
    send_request(CMD_WRITE, 1'b0, 2'd0, 8'd0, 1'b1, 2'd0, '0);
    send_request(CMD_READ, 1'b1, 2'd0, 8'd0, 1'b0, 2'd0, '0);

    // random phases over idle modes and configurations
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      if (ph < PHASES / 2) begin
        for (int k = 0; k < PACKED; k++) begin
          in_len[k*LEN_W +: LEN_W]  = LEN_W'($urandom_range(0, 20));
          out_len[k*LEN_W +: LEN_W] = LEN_W'($urandom_range(0, 20));
        end
        apply_config(in_len, out_len, 3'($urandom_range(1, 4)), 3'($urandom_range(1, 4)));
      end else begin
        apply_config($urandom, $urandom, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
      end
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      repeat (PHASE_ITEMS) random_request();
    end

    // drain and let the pipeline settle
    wait_idle();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && answers_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
